FILE: sv/srsf_pkg.sv
// Shared types, bounds and the per-channel range check and slew limit function
// for the sensor range and slew filter. No dependencies.
`default_nettype none

package srsf_pkg;

  localparam int unsigned ChanW = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic signed [ChanW-1:0] TempMin = -20'sd4000;
  localparam logic signed [ChanW-1:0] TempMax = 20'sd8500;
  localparam logic signed [ChanW-1:0] PressMin = 20'sd30000;
  localparam logic signed [ChanW-1:0] PressMax = 20'sd110000;
  localparam logic signed [ChanW-1:0] HumMin = 20'sd0;
  localparam logic signed [ChanW-1:0] HumMax = 20'sd10000;

  localparam logic [12:0] TempRateRst = 13'd100;
  localparam logic [15:0] PressRateRst = 16'd1000;
  localparam logic [12:0] HumRateRst = 13'd500;
  localparam logic [7:0] SettleRst = 8'd1;

  typedef enum logic [1:0] {
    DiagOk    = 2'd0,
    DiagRange = 2'd1,
    DiagRate  = 2'd2,
    DiagComm  = 2'd3
  } diag_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTempRate  = 2'd0,
    CfgPressRate = 2'd1,
    CfgHumRate   = 2'd2,
    CfgSettle    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ChanW-1:0] held;
    diag_e                   diag;
  } chan_res_t;

  function automatic chan_res_t run_channel(
    input logic                    ok,
    input logic signed [ChanW-1:0] raw,
    input logic signed [ChanW-1:0] lo,
    input logic signed [ChanW-1:0] hi,
    input logic signed [ChanW-1:0] limit,
    input logic signed [ChanW-1:0] held,
    input logic                    settling
  );
    chan_res_t               res;
    logic signed [ChanW-1:0] diff;
    res.held = held;
    res.diag = DiagOk;
    diff = raw - held;
    if (!ok) begin
      res.diag = DiagComm;
    end else if (raw < lo || raw > hi) begin
      res.diag = DiagRange;
    end else if (settling) begin
      res.held = raw;
    end else if (diff > limit) begin
      res.held = held + limit;
      res.diag = DiagRate;
    end else if (diff < -limit) begin
      res.held = held - limit;
      res.diag = DiagRate;
    end else begin
      res.held = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sensor_range_slew_filter_core.sv
// Top level of the sensor range check and slew-rate filter: config registers,
// held values, settle counter and result register. Depends on srsf_pkg.
//
// Usage: one request on the input channel is one sensor tick with three raw
// readings and their read-ok flags. A request is taken when in_valid_i is high
// and in_stall_o is low; the matching result appears on the output channel in
// the next cycle and is taken when out_valid_o is high and out_stall_i is low.
// One tick is processed per cycle while the receiver does not stall, so ticks
// may arrive back to back. A single result register follows the clamp logic.
// While the receiver stalls a waiting result, in_stall_o is raised in the same
// cycle and the result and all held values stay unchanged; a result taken in a
// cycle frees room for a new request in that same cycle.
// Config writes (cfg_valid_i, always ready) set the three rate limits and the
// settle length; writing the settle length restarts the settle window. Write
// them only while no tick is in flight.
// Reset clears the held values to zero, loads the default limits and a settle
// length of one, and empties the result register.
`default_nettype none

module sensor_range_slew_filter_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [15:0]                  temp_raw_i,
  input  wire logic                                temp_ok_i,
  input  wire logic [17:0]                         press_raw_i,
  input  wire logic                                press_ok_i,
  input  wire logic [15:0]                         hum_raw_i,
  input  wire logic                                hum_ok_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [14:0]                       temp_filtered_o,
  output logic [1:0]                               temp_diag_o,
  output logic [16:0]                              press_filtered_o,
  output logic [1:0]                               press_diag_o,
  output logic [13:0]                              hum_filtered_o,
  output logic [1:0]                               hum_diag_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [srsf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [srsf_pkg::CfgDataW-1:0]       cfg_data_i
);

  logic [12:0] temp_rate_q;
  logic [15:0] press_rate_q;
  logic [12:0] hum_rate_q;
  logic [7:0]  settle_cnt_q, settle_cnt_d;

  logic signed [14:0] held_temp_q, held_temp_d;
  logic [16:0]        held_press_q, held_press_d;
  logic [13:0]        held_hum_q, held_hum_d;
  logic [1:0]         temp_diag_q, press_diag_q, hum_diag_q;
  logic               out_valid_q, out_valid_d;

  logic                 in_take;
  logic                 cfg_take;
  logic                 settling;
  srsf_pkg::chan_res_t  temp_res, press_res, hum_res;
  srsf_pkg::cfg_reg_e   cfg_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_take    = cfg_valid_i;
  assign cfg_sel     = srsf_pkg::cfg_reg_e'(cfg_index_i);

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign settling   = (settle_cnt_q != 8'd0);

  always_comb begin
    temp_res = srsf_pkg::run_channel(temp_ok_i,
      {{4{temp_raw_i[15]}}, temp_raw_i},
      srsf_pkg::TempMin, srsf_pkg::TempMax,
      {7'd0, temp_rate_q},
      {{5{held_temp_q[14]}}, held_temp_q}, settling);
    press_res = srsf_pkg::run_channel(press_ok_i,
      {2'd0, press_raw_i},
      srsf_pkg::PressMin, srsf_pkg::PressMax,
      {4'd0, press_rate_q},
      {3'd0, held_press_q}, settling);
    hum_res = srsf_pkg::run_channel(hum_ok_i,
      {4'd0, hum_raw_i},
      srsf_pkg::HumMin, srsf_pkg::HumMax,
      {7'd0, hum_rate_q},
      {6'd0, held_hum_q}, settling);
  end

  always_comb begin
    held_temp_d  = temp_res.held[14:0];
    held_press_d = press_res.held[16:0];
    held_hum_d   = hum_res.held[13:0];
    out_valid_d  = out_valid_q;
    if (in_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    settle_cnt_d = settle_cnt_q;
    if (cfg_take && cfg_sel == srsf_pkg::CfgSettle) begin
      settle_cnt_d = cfg_data_i[7:0];
    end else if (in_take && settling) begin
      settle_cnt_d = settle_cnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_rate_q  <= srsf_pkg::TempRateRst;
      press_rate_q <= srsf_pkg::PressRateRst;
      hum_rate_q   <= srsf_pkg::HumRateRst;
    end else if (cfg_take) begin
      unique case (cfg_sel)
        srsf_pkg::CfgTempRate:  temp_rate_q  <= cfg_data_i[12:0];
        srsf_pkg::CfgPressRate: press_rate_q <= cfg_data_i[15:0];
        srsf_pkg::CfgHumRate:   hum_rate_q   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_cnt_q <= srsf_pkg::SettleRst;
      out_valid_q  <= 1'b0;
      held_temp_q  <= '0;
      held_press_q <= '0;
      held_hum_q   <= '0;
    end else begin
      settle_cnt_q <= settle_cnt_d;
      out_valid_q  <= out_valid_d;
      if (in_take) begin
        held_temp_q  <= held_temp_d;
        held_press_q <= held_press_d;
        held_hum_q   <= held_hum_d;
      end
    end
  end

  // diag codes are payload only
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      temp_diag_q  <= temp_res.diag;
      press_diag_q <= press_res.diag;
      hum_diag_q   <= hum_res.diag;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign temp_filtered_o  = held_temp_q;
  assign press_filtered_o = held_press_q;
  assign hum_filtered_o   = held_hum_q;
  assign temp_diag_o      = temp_diag_q;
  assign press_diag_o     = press_diag_q;
  assign hum_diag_o       = hum_diag_q;

endmodule

`default_nettype wire
